FILE: sv/mqttrx_pkg.sv
// Shared types and codes for the MQTT receive packet parser.
// Holds packet type codes, result role and verdict codes, and the result struct.
// No dependencies.
package mqttrx_pkg;

    // Packet type codes (upper nibble of the fixed header's first byte)
    localparam logic [3:0] KIND_CONNACK  = 4'd2;
    localparam logic [3:0] KIND_PUBLISH  = 4'd3;
    localparam logic [3:0] KIND_SUBACK   = 4'd9;
    localparam logic [3:0] KIND_PINGRESP = 4'd13;

    // Role of each passed byte
    localparam logic [1:0] ROLE_HEADER  = 2'd0;
    localparam logic [1:0] ROLE_TOPIC   = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_DROPPED = 2'd3;

    // Verdict on the final byte
    localparam logic [2:0] VERDICT_INVALID  = 3'd0;
    localparam logic [2:0] VERDICT_CONNACK  = 3'd1;
    localparam logic [2:0] VERDICT_SUBACK   = 3'd2;
    localparam logic [2:0] VERDICT_PINGRESP = 3'd3;
    localparam logic [2:0] VERDICT_PUBLISH  = 3'd4;

    // One result transaction
    typedef struct packed {
        logic [1:0] role;
        logic [7:0] out_byte;
        logic [7:0] position;
        logic       done_res;
        logic [2:0] verdict;
        logic [7:0] payload_count;
        logic [5:0] topic_count;
    } res_t;

endpackage

FILE: sv/mqttrx_in_if.sv
// Input channel of the MQTT receive packet parser: one packet byte per transaction.
// Standalone interface, no dependencies.
interface mqttrx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

FILE: sv/mqttrx_out_if.sv
// Result channel of the MQTT receive packet parser: one result per input byte.
// Standalone interface, no dependencies.
interface mqttrx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] role;
    logic [7:0] out_byte;
    logic [7:0] position;
    logic       done_res;
    logic [2:0] verdict;
    logic [7:0] payload_count;
    logic [5:0] topic_count;

    modport source (output valid, output role, output out_byte, output position,
                    output done_res, output verdict, output payload_count,
                    output topic_count, input ready);
    modport sink   (input valid, input role, input out_byte, input position,
                    input done_res, input verdict, input payload_count,
                    input topic_count, output ready);
endinterface

FILE: sv/mqttrx_core.sv
// Per-byte parse logic of the MQTT receive packet parser: phase state and counters.
// Produces the result for the byte being accepted; depends on mqttrx_pkg.
module mqttrx_core
    import mqttrx_pkg::*;
#(
    parameter int TOPIC_MAX   = 64,
    parameter int PAYLOAD_MAX = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       last_byte,
    output res_t       res
);

    localparam int TW = $clog2(TOPIC_MAX);
    localparam int PW = $clog2(PAYLOAD_MAX);
    localparam logic [TW-1:0] TOPIC_LIMIT   = TW'(TOPIC_MAX - 1);
    localparam logic [PW-1:0] PAYLOAD_LIMIT = PW'(PAYLOAD_MAX - 1);
    // Byte index only matters up to byte 3, so the count saturates just past it
    localparam logic [2:0] CNT_SAT = 3'd4;
    localparam logic [2:0] CNT_CONNACK_CODE = 3'd3;
    localparam logic [2:0] CNT_MIN_LEN = 3'd2;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_BODY,
        PH_RLEN,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_PAYLOAD
    } phase_t;

    phase_t        phase_reg,        phase_next;
    logic [2:0]    cnt_reg,          cnt_next;
    logic [3:0]    kind_reg,         kind_next;
    logic          connack_ok_reg,   connack_ok_next;
    logic [15:0]   topic_left_reg,   topic_left_next;
    logic [TW-1:0] topic_kept_reg,   topic_kept_next;
    logic [PW-1:0] payload_kept_reg, payload_kept_next;

    // Advance the parse by one byte and form its result
    always_comb
    begin
        phase_next        = phase_reg;
        kind_next         = kind_reg;
        connack_ok_next   = connack_ok_reg;
        topic_left_next   = topic_left_reg;
        topic_kept_next   = topic_kept_reg;
        payload_kept_next = payload_kept_reg;
        cnt_next          = (cnt_reg < CNT_SAT) ? cnt_reg + 3'd1 : cnt_reg;

        res               = '0;
        res.role          = ROLE_HEADER;
        res.out_byte      = rx_byte;
        res.done_res      = last_byte;
        res.verdict       = VERDICT_INVALID;

        case (phase_reg)
            PH_BODY:
            begin
                if (cnt_reg == CNT_CONNACK_CODE && kind_reg == KIND_CONNACK)
                begin
                    connack_ok_next = (rx_byte == 8'h00);
                end
            end
            PH_RLEN:
            begin
                // Skip remaining-length bytes until the continuation bit clears
                if (!rx_byte[7])
                begin
                    phase_next = PH_TLEN_HI;
                end
            end
            PH_TLEN_HI:
            begin
                topic_left_next = {rx_byte, 8'h00};
                phase_next      = PH_TLEN_LO;
            end
            PH_TLEN_LO:
            begin
                topic_left_next = {topic_left_reg[15:8], topic_left_reg[7:0] | rx_byte};
                phase_next      = (topic_left_next != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
            end
            PH_TOPIC:
            begin
                if (topic_kept_reg < TOPIC_LIMIT)
                begin
                    res.role        = ROLE_TOPIC;
                    res.position    = 8'(topic_kept_reg);
                    topic_kept_next = topic_kept_reg + TW'(1);
                end
                else
                begin
                    res.role = ROLE_DROPPED;
                end
                topic_left_next = topic_left_reg - 16'd1;
                if (topic_left_next == 16'd0)
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (payload_kept_reg < PAYLOAD_LIMIT)
                begin
                    res.role          = ROLE_PAYLOAD;
                    res.position      = 8'(payload_kept_reg);
                    payload_kept_next = payload_kept_reg + PW'(1);
                end
                else
                begin
                    res.role = ROLE_DROPPED;
                end
            end
            default:
            begin
                // First header byte: classify and clear per-packet state
                kind_next         = rx_byte[7:4];
                connack_ok_next   = 1'b0;
                topic_left_next   = 16'd0;
                topic_kept_next   = '0;
                payload_kept_next = '0;
                phase_next        = (rx_byte[7:4] == KIND_PUBLISH) ? PH_RLEN : PH_BODY;
            end
        endcase

        // Give the verdict on the final byte and rearm for the next packet
        if (last_byte)
        begin
            if (cnt_next >= CNT_MIN_LEN)
            begin
                if (kind_next == KIND_CONNACK)
                begin
                    res.verdict = connack_ok_next ? VERDICT_CONNACK : VERDICT_INVALID;
                end
                else if (kind_next == KIND_SUBACK)
                begin
                    res.verdict = VERDICT_SUBACK;
                end
                else if (kind_next == KIND_PINGRESP)
                begin
                    res.verdict = VERDICT_PINGRESP;
                end
                else if (kind_next == KIND_PUBLISH && phase_next == PH_PAYLOAD)
                begin
                    res.verdict = VERDICT_PUBLISH;
                end
            end
            if (res.verdict == VERDICT_PUBLISH)
            begin
                res.payload_count = 8'(payload_kept_next);
                res.topic_count   = 6'(topic_kept_next);
            end
            phase_next = PH_FIRST;
            cnt_next   = 3'd0;
        end
    end

    // Hold parse state; advance on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FIRST;
            cnt_reg          <= 3'd0;
            kind_reg         <= 4'd0;
            connack_ok_reg   <= 1'b0;
            topic_left_reg   <= 16'd0;
            topic_kept_reg   <= '0;
            payload_kept_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            kind_reg         <= kind_next;
            connack_ok_reg   <= connack_ok_next;
            topic_left_reg   <= topic_left_next;
            topic_kept_reg   <= topic_kept_next;
            payload_kept_reg <= payload_kept_next;
        end
    end

endmodule

FILE: sv/mqttrx_skid.sv
// Two-entry result buffer of the MQTT receive packet parser: output register plus skid.
// Keeps the input side open while one result waits; depends on mqttrx_pkg.
module mqttrx_skid
    import mqttrx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Move skid or input into the output register when it frees; park otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Hold payloads alongside their valid bits
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid && in_ready)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

FILE: sv/mqtt_rx_packet_parser.sv
// Top level of the MQTT receive packet parser.
// Depends on mqttrx_pkg, mqttrx_in_if, mqttrx_out_if, mqttrx_core and mqttrx_skid.
//
// Usage:
//   rx carries one received packet byte per transaction, with last_byte set on
//   the final byte of each packet. result returns exactly one transaction per
//   byte: its role (header/ignored, topic, payload, dropped), the byte itself,
//   its position within topic or payload, and on the final byte the verdict,
//   with the kept topic and payload counts for a valid PUBLISH.
//   The result is registered: while the output register is free, a byte's result
//   shows right after the edge that accepts it. One byte is taken per cycle while
//   the result buffer is not full, as the parse core updates its phase per byte.
//   A two-entry result buffer sits on the output, so rx.ready stays high while
//   one result waits; it drops only when two results are held because the
//   receiver stalls, and rises again as soon as result is taken.
//   Reset clears the buffer and returns the parser to expect the first byte of
//   a packet. A zero verdict tells the receiver to discard that packet's output.
module mqtt_rx_packet_parser
    import mqttrx_pkg::*;
#(
    parameter int TOPIC_MAX   = 64,
    parameter int PAYLOAD_MAX = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    mqttrx_in_if.sink     rx,
    mqttrx_out_if.source  result
);

    logic accept;
    res_t core_res;
    res_t buf_res;

    assign accept = rx.valid && rx.ready;

    // Parse the accepted byte
    mqttrx_core #(
        .TOPIC_MAX   (TOPIC_MAX),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .last_byte (rx.last_byte),
        .res       (core_res)
    );

    // Register the result and absorb receiver stalls
    mqttrx_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .in_data   (core_res),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (buf_res)
    );

    // Unpack the result transaction onto the channel
    assign result.role          = buf_res.role;
    assign result.out_byte      = buf_res.out_byte;
    assign result.position      = buf_res.position;
    assign result.done_res      = buf_res.done_res;
    assign result.verdict       = buf_res.verdict;
    assign result.payload_count = buf_res.payload_count;
    assign result.topic_count   = buf_res.topic_count;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for mqtt_rx_packet_parser: streams packet bytes and checks each
// per-byte result against an in-bench parse model. Depends on mqttrx_pkg, mqttrx_in_if,
// mqttrx_out_if and the parser RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mqttrx_pkg::*;

    localparam int TOPIC_MAX   = 64;
    localparam int PAYLOAD_MAX = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 60;
    localparam int MAX_REPORTS  = 40;
    localparam int TARGET_BYTES = 490;

    typedef enum logic [2:0] {
        P_FIRST, P_BODY, P_RLEN, P_TLEN_HI, P_TLEN_LO, P_TOPIC, P_PAYLOAD
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    logic clk;
    logic rst_n;

    mqttrx_in_if  rx_ch ();
    mqttrx_out_if res_ch ();

    mqtt_rx_packet_parser #(
        .TOPIC_MAX   (TOPIC_MAX),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    // Parse model state
    parse_phase_t ph          = P_FIRST;
    logic [15:0]  seen_cnt    = '0;
    logic [3:0]   kind        = '0;
    logic         ack_ok      = 1'b0;
    logic [15:0]  topic_rem   = '0;
    logic [15:0]  topic_got   = '0;
    logic [15:0]  payload_got = '0;

    rx_item_t    rx_bytes_q[$];
    res_t        byte_results_q[$];
    logic [7:0]  pkt_buf[$];

    int  n_total;
    int  n_in;
    int  n_out;
    int  n_errors;
    int  n_dropped;
    int  n_stalled;
    int  cycles;
    int  hold_left;
    bit  hold_done;
    bit  rx_taken;
    int  verdict_tally[5];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset: hold low from the start, release on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Advance the parse model by one byte and return the result it implies
    function automatic res_t parse_byte(input logic [7:0] b, input logic last);
        res_t        r;
        logic [15:0] idx;
        r          = '0;
        r.out_byte = b;
        r.done_res = last;
        idx        = seen_cnt;
        if (seen_cnt != 16'hFFFF)
            seen_cnt++;
        case (ph)
            P_BODY:
            begin
                if (idx == 16'd3 && kind == KIND_CONNACK)
                    ack_ok = (b == 8'h00);
            end
            P_RLEN:
            begin
                if (!b[7])
                    ph = P_TLEN_HI;
            end
            P_TLEN_HI:
            begin
                topic_rem = {b, 8'h00};
                ph        = P_TLEN_LO;
            end
            P_TLEN_LO:
            begin
                topic_rem = topic_rem | {8'h00, b};
                if (topic_rem != 16'd0)
                    ph = P_TOPIC;
                else
                    ph = P_PAYLOAD;
            end
            P_TOPIC:
            begin
                if (topic_got < TOPIC_MAX - 1)
                begin
                    r.role     = ROLE_TOPIC;
                    r.position = topic_got[7:0];
                    topic_got++;
                end
                else
                    r.role = ROLE_DROPPED;
                topic_rem--;
                if (topic_rem == 16'd0)
                    ph = P_PAYLOAD;
            end
            P_PAYLOAD:
            begin
                if (payload_got < PAYLOAD_MAX - 1)
                begin
                    r.role     = ROLE_PAYLOAD;
                    r.position = payload_got[7:0];
                    payload_got++;
                end
                else
                    r.role = ROLE_DROPPED;
            end
            default:
            begin
                kind        = b[7:4];
                ack_ok      = 1'b0;
                topic_rem   = '0;
                topic_got   = '0;
                payload_got = '0;
                if (kind == KIND_PUBLISH)
                    ph = P_RLEN;
                else
                    ph = P_BODY;
            end
        endcase

        // Verdict on the final byte, then rearm for the next packet
        if (last)
        begin
            if (seen_cnt >= 16'd2)
            begin
                if (kind == KIND_CONNACK)
                    r.verdict = ack_ok ? VERDICT_CONNACK : VERDICT_INVALID;
                else if (kind == KIND_SUBACK)
                    r.verdict = VERDICT_SUBACK;
                else if (kind == KIND_PINGRESP)
                    r.verdict = VERDICT_PINGRESP;
                else if (kind == KIND_PUBLISH && ph == P_PAYLOAD)
                    r.verdict = VERDICT_PUBLISH;
            end
            if (r.verdict == VERDICT_PUBLISH)
            begin
                r.payload_count = payload_got[7:0];
                r.topic_count   = topic_got[5:0];
            end
            ph       = P_FIRST;
            seen_cnt = '0;
        end
        return r;
    endfunction

    // Queue the first len bytes of pkt_buf as one packet, last flag on the final one
    task automatic push_packet(input int len);
        rx_item_t item;
        for (int i = 0; i < len; i++)
        begin
            item.data = pkt_buf[i];
            item.last = (i == len - 1);
            rx_bytes_q.push_back(item);
        end
    endtask

    // Build a PUBLISH: header, remaining-length field, topic length, topic, payload
    task automatic build_publish(input int tlen, input int plen, input int rlen_len);
        logic [3:0]  flags;
        logic [15:0] tl;
        flags = 4'($urandom_range(0, 15));
        tl    = 16'(tlen);
        pkt_buf.delete();
        pkt_buf.push_back({KIND_PUBLISH, flags});
        for (int i = 0; i < rlen_len - 1; i++)
            pkt_buf.push_back(8'($urandom) | 8'h80);
        pkt_buf.push_back(8'($urandom) & 8'h7F);
        pkt_buf.push_back(tl[15:8]);
        pkt_buf.push_back(tl[7:0]);
        for (int i = 0; i < tlen + plen; i++)
            pkt_buf.push_back(8'($urandom));
    endtask

    // Build a short control packet of the given type; CONNACK return code mostly zero
    task automatic build_control(input logic [3:0] kind_code, input int len);
        logic [3:0] flags;
        flags = 4'($urandom_range(0, 15));
        pkt_buf.delete();
        pkt_buf.push_back({kind_code, flags});
        for (int i = 1; i < len; i++)
            pkt_buf.push_back(8'($urandom));
        if (kind_code == KIND_CONNACK && len > 3 && $urandom_range(0, 3) != 0)
            pkt_buf[3] = 8'h00;
    endtask

    // Build one random well-formed packet
    task automatic build_random_packet();
        int sel;
        int tlen;
        int plen;
        sel = $urandom_range(0, 5);
        if (sel <= 2)
        begin
            tlen = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
            plen = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 262)
                                                : $urandom_range(0, 10);
            build_publish(tlen, plen, ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8)
                                                                  : $urandom_range(1, 4));
        end
        else if (sel == 3)
            build_control(KIND_CONNACK, $urandom_range(0, 4) == 0 ? $urandom_range(2, 3) : 4);
        else if (sel == 4)
            build_control(KIND_SUBACK, $urandom_range(2, 5));
        else
            build_control(KIND_PINGRESP, 2);
    endtask

    // Stimulus: directed packets, one oversized publish, then random packets
    initial
    begin : stim
        int sel;
        int len;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = '0;
        rx_ch.last_byte = 1'b0;
        res_ch.ready    = 1'b0;

        // One-byte packet is too short
        pkt_buf = '{8'h30};
        push_packet(1);
        // CONNACK accepted, then rejected on a nonzero return code, then too short for one
        pkt_buf = '{8'h20, 8'h02, 8'h00, 8'h00};
        push_packet(4);
        pkt_buf = '{8'h20, 8'h02, 8'h01, 8'hFF};
        push_packet(4);
        pkt_buf = '{8'h20, 8'h02};
        push_packet(2);
        // SUBACK, PINGRESP and an unknown type
        pkt_buf = '{8'h90, 8'h03};
        push_packet(2);
        pkt_buf = '{8'hD0, 8'h00};
        push_packet(2);
        pkt_buf = '{8'hF7, 8'h5A};
        push_packet(2);
        // PUBLISH ending inside the remaining-length field
        pkt_buf = '{8'h3F, 8'hFF, 8'h80};
        push_packet(3);
        // PUBLISH with one topic byte and one payload byte
        pkt_buf = '{8'h30, 8'h04, 8'h00, 8'h01, 8'h61, 8'hAA};
        push_packet(6);
        // PUBLISH whose topic runs past the end
        pkt_buf = '{8'h32, 8'h03, 8'h00, 8'h05, 8'h41};
        push_packet(5);

        // Overflow both the topic and the payload store
        build_publish(TOPIC_MAX + 3, PAYLOAD_MAX + 2, 2);
        push_packet(pkt_buf.size());

        // Mostly well-formed packets, some cut short, some noise
        while (rx_bytes_q.size() < TARGET_BYTES)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                build_random_packet();
                push_packet(pkt_buf.size());
            end
            else if (sel < 85)
            begin
                build_random_packet();
                push_packet($urandom_range(1, pkt_buf.size()));
            end
            else
            begin
                len = $urandom_range(1, 6);
                pkt_buf.delete();
                for (int i = 0; i < len; i++)
                    pkt_buf.push_back(8'($urandom));
                push_packet(len);
            end
        end
        n_total = rx_bytes_q.size();
    end

    // Driver: offer the next byte on the falling edge, hold valid until accepted
    always @(negedge clk)
    begin : drv
        int       pct;
        rx_item_t item;
        pct = (n_in < n_total / 3) ? 22 : (n_in < 2 * n_total / 3) ? 78 : 0;
        if (rx_taken)
            void'(rx_bytes_q.pop_front());
        if (!rst_n)
            rx_ch.valid <= 1'b0;
        else if (!rx_ch.valid || rx_taken)
        begin
            if (rx_bytes_q.size() > 0 && $urandom_range(0, 99) >= pct)
            begin
                item             = rx_bytes_q[0];
                rx_ch.valid     <= 1'b1;
                rx_ch.rx_byte   <= item.data;
                rx_ch.last_byte <= item.last;
            end
            else
                rx_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off late in the run to fill the parser
    always @(negedge clk)
    begin : rcv
        int pct;
        pct = (n_in < n_total / 3) ? 78 : (n_in < 2 * n_total / 3) ? 22 : 0;
        if (!hold_done && n_total > 0 && n_in >= (n_total * 5) / 6)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            res_ch.ready <= ($urandom_range(0, 99) >= pct);
    end

    // Report one field mismatch
    task automatic report_field(input string name, input int want, input int got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    endtask

    // Monitor: predict on each accepted byte, check each accepted result in order
    always @(posedge clk)
    begin : mon
        res_t want;
        res_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("mqtt_rx_packet_parser regression: fail");
            $finish;
        end
        else
        begin
            rx_taken = rst_n && rx_ch.valid && rx_ch.ready;
            if (rx_taken)
            begin
                want = parse_byte(rx_ch.rx_byte, rx_ch.last_byte);
                byte_results_q.push_back(want);
                n_in++;
                if (want.done_res)
                    verdict_tally[want.verdict]++;
                if (want.role == ROLE_DROPPED)
                    n_dropped++;
            end
            if (rst_n && rx_ch.valid && !rx_ch.ready)
                n_stalled++;

            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got.role          = res_ch.role;
                got.out_byte      = res_ch.out_byte;
                got.position      = res_ch.position;
                got.done_res      = res_ch.done_res;
                got.verdict       = res_ch.verdict;
                got.payload_count = res_ch.payload_count;
                got.topic_count   = res_ch.topic_count;
                n_out++;
                if (byte_results_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result transaction: expected none, actual 0x%0h",
                             $time, got);
                end
                else
                begin
                    want = byte_results_q.pop_front();
                    if (got.role !== want.role)
                        report_field("role", want.role, got.role);
                    if (got.out_byte !== want.out_byte)
                        report_field("out_byte", want.out_byte, got.out_byte);
                    if (got.position !== want.position)
                        report_field("position", want.position, got.position);
                    if (got.done_res !== want.done_res)
                        report_field("done_res", want.done_res, got.done_res);
                    if (got.verdict !== want.verdict)
                        report_field("verdict", want.verdict, got.verdict);
                    if (got.payload_count !== want.payload_count)
                        report_field("payload_count", want.payload_count, got.payload_count);
                    if (got.topic_count !== want.topic_count)
                        report_field("topic_count", want.topic_count, got.topic_count);
                end
            end
        end
    end

    // End of run: drain, settle, then give the verdict
    initial
    begin : finish_run
        wait (rst_n === 1'b1);
        do
            @(posedge clk);
        while (rx_bytes_q.size() > 0 || byte_results_q.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (byte_results_q.size() > 0)
        begin
            n_errors++;
            $display("%0t: %0d expected result transactions never arrived", $time,
                     byte_results_q.size());
        end
        $display("Streamed %0d bytes, checked %0d results, %0d dropped, %0d stall cycles.",
                 n_in, n_out, n_dropped, n_stalled);
        $display("Verdicts: invalid %0d, connack %0d, suback %0d, pingresp %0d, publish %0d.",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
                 verdict_tally[4]);
        if (n_errors == 0)
            $display("mqtt_rx_packet_parser regression: pass");
        else
            $display("mqtt_rx_packet_parser regression: fail");
        $finish;
    end

endmodule

FILE: mqtt_rx_packet_parser.f
sv/mqttrx_pkg.sv
sv/mqttrx_in_if.sv
sv/mqttrx_out_if.sv
sv/mqttrx_core.sv
sv/mqttrx_skid.sv
sv/mqtt_rx_packet_parser.sv
verif/tb_top.sv
